[rtl/core/ots_pkg.sv]
// package of types, codes and lookup functions for the token scanner
package ots_pkg;

   // scanner modes
   typedef enum logic [3:0] {
      M_IDLE     = 4'd0,
      M_NAME     = 4'd1,
      M_ZEROS    = 4'd2,
      M_DEC      = 4'd3,
      M_HEX      = 4'd4,
      M_FRAC     = 4'd5,
      M_EXPSIGN  = 4'd6,
      M_EXPFIRST = 4'd7,
      M_EXPDIG   = 4'd8,
      M_STRING   = 4'd9,
      M_PAREN    = 4'd10,
      M_COMMENT  = 4'd11,
      M_CSTAR    = 4'd12,
      M_LT       = 4'd13,
      M_GT       = 4'd14,
      M_COLON    = 4'd15
   } mode_type;

   // token classes
   localparam logic [6:0] C_NONE   = 7'd0;
   localparam logic [6:0] C_IDENT  = 7'd1;
   localparam logic [6:0] C_NOT    = 7'd2;
   localparam logic [6:0] C_AND    = 7'd3;
   localparam logic [6:0] C_OR     = 7'd4;
   localparam logic [6:0] C_IMPORT = 7'd5;
   localparam logic [6:0] C_MODULE = 7'd6;
   localparam logic [6:0] C_TRUE   = 7'd7;
   localparam logic [6:0] C_FALSE  = 7'd8;
   localparam logic [6:0] C_NIL    = 7'd9;
   localparam logic [6:0] C_PROC   = 7'd10;
   localparam logic [6:0] C_BEGIN  = 7'd11;
   localparam logic [6:0] C_END    = 7'd12;
   localparam logic [6:0] C_RET    = 7'd13;
   localparam logic [6:0] C_COLON  = 7'd14;
   localparam logic [6:0] C_SEMI   = 7'd15;
   localparam logic [6:0] C_ASSIGN = 7'd16;
   localparam logic [6:0] C_IF     = 7'd17;
   localparam logic [6:0] C_ELIF   = 7'd18;
   localparam logic [6:0] C_ELSE   = 7'd19;
   localparam logic [6:0] C_CASE   = 7'd20;
   localparam logic [6:0] C_THEN   = 7'd21;
   localparam logic [6:0] C_ADD    = 7'd22;
   localparam logic [6:0] C_SUB    = 7'd23;
   localparam logic [6:0] C_MUL    = 7'd24;
   localparam logic [6:0] C_DIV    = 7'd25;
   localparam logic [6:0] C_MOD    = 7'd27;
   localparam logic [6:0] C_WHILE  = 7'd28;
   localparam logic [6:0] C_FOR    = 7'd29;
   localparam logic [6:0] C_TO     = 7'd30;
   localparam logic [6:0] C_BY     = 7'd31;
   localparam logic [6:0] C_DO     = 7'd32;
   localparam logic [6:0] C_REP    = 7'd33;
   localparam logic [6:0] C_UNTIL  = 7'd34;
   localparam logic [6:0] C_TYPE   = 7'd35;
   localparam logic [6:0] C_PTR    = 7'd36;
   localparam logic [6:0] C_VAR    = 7'd37;
   localparam logic [6:0] C_CONST  = 7'd38;
   localparam logic [6:0] C_ARR    = 7'd39;
   localparam logic [6:0] C_OF     = 7'd40;
   localparam logic [6:0] C_REC    = 7'd41;
   localparam logic [6:0] C_INTDEC = 7'd42;
   localparam logic [6:0] C_INTHEX = 7'd43;
   localparam logic [6:0] C_REAL   = 7'd45;
   localparam logic [6:0] C_STR    = 7'd46;
   localparam logic [6:0] C_STRHEX = 7'd47;
   localparam logic [6:0] C_EQ     = 7'd48;
   localparam logic [6:0] C_NOEQ   = 7'd49;
   localparam logic [6:0] C_LESS   = 7'd50;
   localparam logic [6:0] C_LESSEQ = 7'd51;
   localparam logic [6:0] C_GREAT  = 7'd52;
   localparam logic [6:0] C_GREATEQ = 7'd53;
   localparam logic [6:0] C_IS     = 7'd54;
   localparam logic [6:0] C_IN     = 7'd55;
   localparam logic [6:0] C_LBR    = 7'd56;
   localparam logic [6:0] C_RBR    = 7'd57;
   localparam logic [6:0] C_LSQ    = 7'd58;
   localparam logic [6:0] C_RSQ    = 7'd59;
   localparam logic [6:0] C_LFIG   = 7'd60;
   localparam logic [6:0] C_RFIG   = 7'd61;

   // error codes
   localparam logic [2:0] E_OK      = 3'd0;
   localparam logic [2:0] E_STRING  = 3'd1;
   localparam logic [2:0] E_COMMENT = 3'd2;
   localparam logic [2:0] E_HEX     = 3'd3;
   localparam logic [2:0] E_EXP     = 3'd4;

   // longest keyword
   localparam int KW_MAX = 9;

   // one result beat
   typedef struct packed {
      logic [6:0]  cls;
      logic [31:0] start;
      logic [15:0] len;
      logic [2:0]  err;
   } tok_type;

   function automatic logic is_dig(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_hexlet(input logic [7:0] c);
      return c >= 8'h41 && c <= 8'h46;
   endfunction

   // class of a one-character symbol, none if the byte is not one
   function automatic logic [6:0] single_class(input logic [7:0] c);
      logic [6:0] r;
      r = C_NONE;
      case (c)
         "+": r = C_ADD;
         "-": r = C_SUB;
         "*": r = C_MUL;
         "/": r = C_DIV;
         "#": r = C_NOEQ;
         "=": r = C_EQ;
         "~": r = C_NOT;
         "&": r = C_AND;
         ";": r = C_SEMI;
         ")": r = C_RBR;
         "[": r = C_LSQ;
         "]": r = C_RSQ;
         "{": r = C_LFIG;
         "}": r = C_RFIG;
         default: r = C_NONE;
      endcase
      return r;
   endfunction

   // keyword lookup over the first nine name characters, packed first char low
   function automatic logic [6:0] kw_class(input logic [4:0] n,
                                           input logic [8*KW_MAX-1:0] s);
      logic [6:0] r;
      r = C_IDENT;
      case (n)
         5'd2: case (s[15:0])
            "FO": r = C_OF;  "OT": r = C_TO;  "NI": r = C_IN;
            "SI": r = C_IS;  "RO": r = C_OR;  "FI": r = C_IF;
            "OD": r = C_DO;  "YB": r = C_BY;
            default: r = C_IDENT;
         endcase
         5'd3: case (s[23:0])
            "DNE": r = C_END;  "VID": r = C_DIV;  "DOM": r = C_MOD;
            "LIN": r = C_NIL;  "ROF": r = C_FOR;  "RAV": r = C_VAR;
            default: r = C_IDENT;
         endcase
         5'd4: case (s[31:0])
            "EURT": r = C_TRUE;  "NEHT": r = C_THEN;  "ESLE": r = C_ELSE;
            "ESAC": r = C_CASE;  "EPYT": r = C_TYPE;
            default: r = C_IDENT;
         endcase
         5'd5: case (s[39:0])
            "YARRA": r = C_ARR;   "NIGEB": r = C_BEGIN; "ESLAF": r = C_FALSE;
            "FISLE": r = C_ELIF;  "ELIHW": r = C_WHILE; "LITNU": r = C_UNTIL;
            "TSNOC": r = C_CONST;
            default: r = C_IDENT;
         endcase
         5'd6: case (s[47:0])
            "NRUTER": r = C_RET;    "DROCER": r = C_REC;
            "TAEPER": r = C_REP;    "ELUDOM": r = C_MODULE;
            "TROPMI": r = C_IMPORT;
            default: r = C_IDENT;
         endcase
         5'd7: r = (s[55:0] == "RETNIOP") ? C_PTR : C_IDENT;
         5'd9: r = (s == "ERUDECORP") ? C_PROC : C_IDENT;
         default: r = C_IDENT;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/oberon_token_scanner.sv]
// top level of the token scanner: one byte in, up to two tokens out
//
// One source byte is taken every cycle while the output side keeps up. Each
// byte is decoded by one combinational pass between the scanner state registers
// and a two-entry result queue; a byte gives zero, one or two tokens. The
// input stalls only when the queue cannot hold the tokens of one more byte, so
// throughput is one byte per cycle with a sink that takes a token every cycle,
// less when bytes yield two tokens. After an error the scanner drops all bytes
// until reset. Names longer than IDENT_BUF are plain identifiers; only the
// first nine characters reach the keyword lookup.
module oberon_token_scanner
   import ots_pkg::*;
#(
   parameter int IDENT_BUF = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // token_class, token_start, token_length,
                                    // error_code, zero fill
   output logic        rsp_tlast    // is_last
);

   localparam int CW = $clog2(IDENT_BUF + 2);

   // scanner state
   mode_type        mode_ff, mode_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [31:0]     beg_ff, beg_in;
   logic [15:0]     size_ff, size_in;
   logic [31:0]     pos_ff, pos_in;
   logic            halt_ff, halt_in;
   logic [8*KW_MAX-1:0] kw_ff, kw_in;

   // result queue
   tok_type q_tok_ff [2];
   logic    q_last_ff [2];
   logic    q_rd_ff;
   logic [1:0] q_cnt_ff;

   logic    acc;
   tok_type t0, t1;
   logic [1:0] nres;
   logic    last_out;

   // room for two beats after any pop this cycle
   assign req_tready = (q_cnt_ff == 2'd0) ||
                       (q_cnt_ff == 2'd1 && rsp_tready);
   assign acc = req_tvalid && req_tready;

   // single-pass decode
   always_comb begin
      logic [7:0] c;
      logic again, ch_hit, fin, err;
      logic [6:0] fcls, scls;
      logic [15:0] sz;
      logic [CW-1:0] nc;
      logic [8*KW_MAX-1:0] kw;
      tok_type tk;
      c = req_tdata;
      mode_in = mode_ff; cnt_in = cnt_ff; beg_in = beg_ff; size_in = size_ff;
      pos_in = pos_ff; halt_in = halt_ff; kw_in = kw_ff;
      t0 = '0; t1 = '0; nres = 2'd0; last_out = 1'b0;
      again = 1'b1; err = 1'b0; fin = 1'b0; fcls = C_NONE;
      ch_hit = 1'b0; scls = C_NONE;
      sz = size_ff; nc = cnt_ff; kw = kw_ff;
      tk = '0;
      // pending token
      unique case (mode_ff)
         M_IDLE: again = 1'b1;
         M_NAME: begin
            if (is_alpha(c) || is_dig(c)) begin
               again = 1'b0;
               sz = (size_ff == 16'hffff) ? size_ff : size_ff + 16'd1;
               if (cnt_ff < CW'(KW_MAX))
                  kw[8*cnt_ff[3:0] +: 8] = c;
               if (cnt_ff <= CW'(IDENT_BUF)) nc = cnt_ff + CW'(1);
            end else begin
               fin = 1'b1;
               fcls = (cnt_ff > CW'(IDENT_BUF) || cnt_ff > CW'(KW_MAX)) ? C_IDENT
                      : kw_class(5'(cnt_ff), kw_ff);
            end
         end
         M_ZEROS, M_DEC: begin
            again = 1'b0;
            if (mode_ff == M_ZEROS && c == "0") beg_in = pos_ff + 32'd1;
            else if (is_dig(c) || is_hexlet(c) || c == "H" || c == "X"
                     || c == ".") begin
               sz = (size_ff == 16'hffff) ? size_ff : size_ff + 16'd1;
               if (is_dig(c)) mode_in = M_DEC;
               else if (is_hexlet(c)) mode_in = M_HEX;
               else if (c == ".") mode_in = M_FRAC;
               else begin
                  fin = 1'b1; fcls = (c == "H") ? C_INTHEX : C_STRHEX;
               end
            end else begin
               again = 1'b1; fin = 1'b1; fcls = C_INTDEC;
            end
         end
         M_HEX: begin
            again = 1'b0;
            if (is_dig(c) || is_hexlet(c) || c == "H" || c == "X") begin
               sz = (size_ff == 16'hffff) ? size_ff : size_ff + 16'd1;
               if (c == "H") begin fin = 1'b1; fcls = C_INTHEX; end
               else if (c == "X") begin fin = 1'b1; fcls = C_STRHEX; end
            end else begin
               err = 1'b1; tk.err = E_HEX;
            end
         end
         M_FRAC, M_EXPDIG: begin
            if (is_dig(c) || (mode_ff == M_FRAC && c == "E")) begin
               again = 1'b0;
               sz = (size_ff == 16'hffff) ? size_ff : size_ff + 16'd1;
               if (c == "E") mode_in = M_EXPSIGN;
            end else begin
               fin = 1'b1; fcls = C_REAL;
            end
         end
         M_EXPSIGN, M_EXPFIRST: begin
            again = 1'b0;
            if (is_dig(c) || (mode_ff == M_EXPSIGN && (c == "+" || c == "-")))
            begin
               sz = (size_ff == 16'hffff) ? size_ff : size_ff + 16'd1;
               mode_in = is_dig(c) ? M_EXPDIG : M_EXPFIRST;
            end else begin
               err = 1'b1; tk.err = E_EXP;
            end
         end
         M_STRING: begin
            again = 1'b0;
            if (c == "\"") begin fin = 1'b1; fcls = C_STR; end
            else sz = (size_ff == 16'hffff) ? size_ff : size_ff + 16'd1;
         end
         M_PAREN: begin
            if (c == "*") begin again = 1'b0; mode_in = M_COMMENT; end
            else begin fin = 1'b1; fcls = C_LBR; sz = 16'd1; end
         end
         M_COMMENT: begin
            again = 1'b0;
            if (c == "*") mode_in = M_CSTAR;
         end
         M_CSTAR: begin
            again = 1'b0;
            if (c == ")") mode_in = M_IDLE;
            else if (c != "*") mode_in = M_COMMENT;
         end
         M_LT, M_GT, M_COLON: begin
            again = (c != "=");
            fin = 1'b1;
            sz = (c == "=") ? 16'd2 : 16'd1;
            if (mode_ff == M_LT) fcls = (c == "=") ? C_LESSEQ : C_LESS;
            else if (mode_ff == M_GT) fcls = (c == "=") ? C_GREATEQ : C_GREAT;
            else fcls = (c == "=") ? C_ASSIGN : C_COLON;
         end
         default: again = 1'b1;
      endcase
      size_in = sz; cnt_in = nc; kw_in = kw;
      if (err) begin
         tk.start = pos_ff;
         t0 = tk; nres = 2'd1; halt_in = 1'b1; mode_in = M_IDLE; again = 1'b0;
      end else if (fin) begin
         t0 = '{cls: fcls, start: beg_in, len: sz, err: E_OK};
         nres = 2'd1; mode_in = M_IDLE;
      end
      // byte seen from idle
      if (again) begin
         beg_in = pos_ff; size_in = 16'd0;
         scls = single_class(c);
         ch_hit = 1'b0;
         if (is_alpha(c)) begin
            mode_in = M_NAME; size_in = 16'd1; cnt_in = CW'(1);
            kw_in[7:0] = c;
         end else if (c == "0") begin
            mode_in = M_ZEROS; beg_in = pos_ff + 32'd1;
         end else if (is_dig(c)) begin
            mode_in = M_DEC; size_in = 16'd1;
         end else if (c == "\"") begin
            mode_in = M_STRING; beg_in = pos_ff + 32'd1;
         end else if (c == "(") mode_in = M_PAREN;
         else if (c == "<") mode_in = M_LT;
         else if (c == ">") mode_in = M_GT;
         else if (c == ":") mode_in = M_COLON;
         else if (scls != C_NONE) ch_hit = 1'b1;
         if (ch_hit) begin
            tk = '{cls: scls, start: pos_ff, len: 16'd1, err: E_OK};
            if (nres == 2'd0) t0 = tk; else t1 = tk;
            nres = nres + 2'd1;
         end
      end
      // end of text: flush what is pending
      if (req_tlast && !halt_in) begin
         tk = '{cls: C_NONE, start: pos_ff, len: 16'd0, err: E_OK};
         err = 1'b0; fin = 1'b1;
         unique case (mode_in)
            M_NAME: tk.cls = (cnt_in > CW'(IDENT_BUF) || cnt_in > CW'(KW_MAX))
                             ? C_IDENT : kw_class(5'(cnt_in), kw_in);
            M_ZEROS, M_DEC: tk.cls = C_INTDEC;
            M_HEX: begin err = 1'b1; tk.err = E_HEX; end
            M_FRAC, M_EXPDIG: tk.cls = C_REAL;
            M_EXPSIGN, M_EXPFIRST: begin err = 1'b1; tk.err = E_EXP; end
            M_STRING: begin err = 1'b1; tk.err = E_STRING; end
            M_PAREN: begin tk.cls = C_LBR; size_in = 16'd1; end
            M_COMMENT, M_CSTAR: begin err = 1'b1; tk.err = E_COMMENT; end
            M_LT: begin tk.cls = C_LESS; size_in = 16'd1; end
            M_GT: begin tk.cls = C_GREAT; size_in = 16'd1; end
            M_COLON: begin tk.cls = C_COLON; size_in = 16'd1; end
            default: fin = 1'b0;
         endcase
         if (fin && !err) begin
            tk.start = beg_in; tk.len = size_in;
         end
         if (err) halt_in = 1'b1;
         if (fin || nres == 2'd0) begin
            if (nres == 2'd0) t0 = tk; else t1 = tk;
            nres = nres + 2'd1;
         end
         last_out = 1'b1;
         mode_in = M_IDLE; cnt_in = '0; beg_in = '0; size_in = '0;
         pos_in = '0;
      end else if (halt_in) begin
         last_out = 1'b1;
      end else begin
         pos_in = pos_ff + 32'd1;
      end
      // a halted scanner drops every byte
      if (halt_ff) begin
         nres = 2'd0; last_out = 1'b0;
         mode_in = mode_ff; cnt_in = cnt_ff; beg_in = beg_ff;
         size_in = size_ff; pos_in = pos_ff; kw_in = kw_ff;
      end
   end

   // scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         cnt_ff  <= '0;
         beg_ff  <= '0;
         size_ff <= '0;
         pos_ff  <= '0;
         halt_ff <= 1'b0;
      end else if (acc) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         beg_ff  <= beg_in;
         size_ff <= size_in;
         pos_ff  <= pos_in;
         halt_ff <= halt_in;
      end
   end

   // name characters kept for the keyword lookup
   always_ff @(posedge clock) begin
      if (acc) kw_ff <= kw_in;
   end

   // result queue: pops one beat, pushes up to two
   always_ff @(posedge clock) begin
      logic pop;
      logic [1:0] cnt;
      logic wr;
      pop = rsp_tvalid && rsp_tready;
      cnt = q_cnt_ff;
      wr = q_rd_ff ^ q_cnt_ff[0];
      if (reset) begin
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (pop) begin
            q_rd_ff <= ~q_rd_ff;
            cnt = cnt - 2'd1;
         end
         if (acc && nres != 2'd0) cnt = cnt + nres;
         q_cnt_ff <= cnt;
      end
      if (acc && nres != 2'd0) begin
         q_tok_ff[wr]  <= t0;
         q_last_ff[wr] <= last_out && nres == 2'd1;
         if (nres == 2'd2) begin
            q_tok_ff[~wr]  <= t1;
            q_last_ff[~wr] <= last_out;
         end
      end
   end

   // head of queue drives the result port
   assign rsp_tvalid = q_cnt_ff != 2'd0;
   assign rsp_tdata  = {6'd0, q_tok_ff[q_rd_ff].err, q_tok_ff[q_rd_ff].len,
                        q_tok_ff[q_rd_ff].start, q_tok_ff[q_rd_ff].cls};
   assign rsp_tlast  = q_last_ff[q_rd_ff];

endmodule

[rtl/core/ots_checker.sv]
// port checker for the token scanner, bound to the top level
module ots_checker
   import ots_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                     && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // the result side is empty straight after reset
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // error beats carry no class and no length, and are marked last
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[57:55] != E_OK |->
         rsp_tdata[6:0] == C_NONE && rsp_tdata[54:39] == 16'd0 && rsp_tlast)
      else $error("malformed error beat");

   // class stays within the defined range and the fill bits are zero
   a_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= C_RFIG && rsp_tdata[63:58] == 6'd0)
      else $error("class out of range");

endmodule

bind oberon_token_scanner ots_checker u_ots_checker (.*);

[dv/tb.sv]
// testbench for the token scanner: directed and random byte streams against a scoreboard
`timescale 1ns / 100ps

// scoreboard: a model of the scanner and a queue of expected tokens
class token_scoreboard;
   typedef struct {
      logic [6:0]  cls;
      logic [31:0] start;
      logic [15:0] len;
      logic [2:0]  err;
      logic        last;
   } token_type;

   token_type           pending_tokens[$];
   ots_pkg::mode_type   mode;
   logic [7:0]          name_buf[16];
   int unsigned         name_len;
   logic [31:0]         tok_begin;
   logic [31:0]         tok_size;
   logic [31:0]         pos_count;
   bit                  stopped;
   int                  errors;
   int                  checked;
   token_type           step_out[$];

   function new();
      mode = ots_pkg::M_IDLE;
      name_len = 0;
      tok_begin = 0;
      tok_size = 0;
      pos_count = 0;
      stopped = 0;
      errors = 0;
      checked = 0;
   endfunction

   function bit dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function bit hexl(logic [7:0] c);
      return c >= "A" && c <= "F";
   endfunction

   function void push(logic [6:0] cls, logic [31:0] start, logic [31:0] len,
                      logic [2:0] err);
      token_type t;
      t.cls = cls;
      t.start = start;
      t.len = len[15:0];
      t.err = err;
      t.last = 0;
      if (step_out.size() < 2) step_out.push_back(t);
   endfunction

   function void halt(logic [31:0] p, logic [2:0] code);
      push(ots_pkg::C_NONE, p, 0, code);
      stopped = 1;
      mode = ots_pkg::M_IDLE;
   endfunction

   function void grow(logic [7:0] c);
      if (tok_size < 32'hFFFF) tok_size++;
      if (mode == ots_pkg::M_NAME) begin
         if (name_len < 16) name_buf[name_len] = c;
         if (name_len <= 16) name_len++;
      end
   endfunction

   // keyword match, written out independently of the package lookup
   function logic [6:0] word_class();
      string s;
      if (name_len > 16) return ots_pkg::C_IDENT;
      s = "";
      for (int i = 0; i < name_len; i++) s = {s, string'(name_buf[i])};
      case (s)
         "ARRAY": return ots_pkg::C_ARR;       "OF": return ots_pkg::C_OF;
         "PROCEDURE": return ots_pkg::C_PROC;  "BEGIN": return ots_pkg::C_BEGIN;
         "END": return ots_pkg::C_END;         "RETURN": return ots_pkg::C_RET;
         "RECORD": return ots_pkg::C_REC;      "POINTER": return ots_pkg::C_PTR;
         "TO": return ots_pkg::C_TO;           "IN": return ots_pkg::C_IN;
         "IS": return ots_pkg::C_IS;           "OR": return ots_pkg::C_OR;
         "DIV": return ots_pkg::C_DIV;         "MOD": return ots_pkg::C_MOD;
         "FALSE": return ots_pkg::C_FALSE;     "TRUE": return ots_pkg::C_TRUE;
         "NIL": return ots_pkg::C_NIL;         "IF": return ots_pkg::C_IF;
         "THEN": return ots_pkg::C_THEN;       "ELSIF": return ots_pkg::C_ELIF;
         "ELSE": return ots_pkg::C_ELSE;       "CASE": return ots_pkg::C_CASE;
         "WHILE": return ots_pkg::C_WHILE;     "DO": return ots_pkg::C_DO;
         "REPEAT": return ots_pkg::C_REP;      "UNTIL": return ots_pkg::C_UNTIL;
         "FOR": return ots_pkg::C_FOR;         "BY": return ots_pkg::C_BY;
         "CONST": return ots_pkg::C_CONST;     "TYPE": return ots_pkg::C_TYPE;
         "VAR": return ots_pkg::C_VAR;         "MODULE": return ots_pkg::C_MODULE;
         "IMPORT": return ots_pkg::C_IMPORT;
         default: return ots_pkg::C_IDENT;
      endcase
   endfunction

   function void close_tok(logic [6:0] cls);
      push(cls, tok_begin, tok_size, ots_pkg::E_OK);
      mode = ots_pkg::M_IDLE;
   endfunction

   // byte seen with no token in progress
   function void from_idle(logic [7:0] c, logic [31:0] p);
      logic [6:0] cls;
      tok_begin = p;
      tok_size = 0;
      cls = ots_pkg::C_NONE;
      if (alpha(c)) begin
         mode = ots_pkg::M_NAME;
         name_len = 0;
         grow(c);
         return;
      end
      if (c == "0") begin
         mode = ots_pkg::M_ZEROS;
         tok_begin = p + 1;
         return;
      end
      if (dig(c)) begin
         mode = ots_pkg::M_DEC;
         grow(c);
         return;
      end
      case (c)
         "\"": begin mode = ots_pkg::M_STRING; tok_begin = p + 1; return; end
         "(": begin mode = ots_pkg::M_PAREN; return; end
         "<": begin mode = ots_pkg::M_LT; return; end
         ">": begin mode = ots_pkg::M_GT; return; end
         ":": begin mode = ots_pkg::M_COLON; return; end
         "+": cls = ots_pkg::C_ADD;
         "-": cls = ots_pkg::C_SUB;
         "*": cls = ots_pkg::C_MUL;
         "/": cls = ots_pkg::C_DIV;
         "#": cls = ots_pkg::C_NOEQ;
         "=": cls = ots_pkg::C_EQ;
         "~": cls = ots_pkg::C_NOT;
         "&": cls = ots_pkg::C_AND;
         ";": cls = ots_pkg::C_SEMI;
         ")": cls = ots_pkg::C_RBR;
         "[": cls = ots_pkg::C_LSQ;
         "]": cls = ots_pkg::C_RSQ;
         "{": cls = ots_pkg::C_LFIG;
         "}": cls = ots_pkg::C_RFIG;
         default: return;
      endcase
      push(cls, p, 1, ots_pkg::E_OK);
   endfunction

   // byte seen inside a token; returns 1 when the byte must be rescanned from idle
   function bit in_token(logic [7:0] c, logic [31:0] p);
      logic [6:0] one, two;
      case (mode)
         ots_pkg::M_NAME: begin
            if (alpha(c) || dig(c)) begin grow(c); return 0; end
            close_tok(word_class());
            return 1;
         end
         ots_pkg::M_ZEROS, ots_pkg::M_DEC: begin
            if (mode == ots_pkg::M_ZEROS && c == "0") begin
               tok_begin = p + 1;
               return 0;
            end
            if (dig(c)) begin grow(c); mode = ots_pkg::M_DEC; return 0; end
            if (hexl(c)) begin grow(c); mode = ots_pkg::M_HEX; return 0; end
            if (c == "H") begin grow(c); close_tok(ots_pkg::C_INTHEX); return 0; end
            if (c == "X") begin grow(c); close_tok(ots_pkg::C_STRHEX); return 0; end
            if (c == ".") begin grow(c); mode = ots_pkg::M_FRAC; return 0; end
            close_tok(ots_pkg::C_INTDEC);
            return 1;
         end
         ots_pkg::M_HEX: begin
            if (dig(c) || hexl(c)) begin grow(c); return 0; end
            if (c == "H") begin grow(c); close_tok(ots_pkg::C_INTHEX); return 0; end
            if (c == "X") begin grow(c); close_tok(ots_pkg::C_STRHEX); return 0; end
            halt(p, ots_pkg::E_HEX);
            return 0;
         end
         ots_pkg::M_FRAC: begin
            if (dig(c)) begin grow(c); return 0; end
            if (c == "E") begin grow(c); mode = ots_pkg::M_EXPSIGN; return 0; end
            close_tok(ots_pkg::C_REAL);
            return 1;
         end
         ots_pkg::M_EXPSIGN, ots_pkg::M_EXPFIRST: begin
            if (mode == ots_pkg::M_EXPSIGN && (c == "+" || c == "-")) begin
               grow(c);
               mode = ots_pkg::M_EXPFIRST;
               return 0;
            end
            if (dig(c)) begin grow(c); mode = ots_pkg::M_EXPDIG; return 0; end
            halt(p, ots_pkg::E_EXP);
            return 0;
         end
         ots_pkg::M_EXPDIG: begin
            if (dig(c)) begin grow(c); return 0; end
            close_tok(ots_pkg::C_REAL);
            return 1;
         end
         ots_pkg::M_STRING: begin
            if (c == "\"") close_tok(ots_pkg::C_STR);
            else grow(c);
            return 0;
         end
         ots_pkg::M_PAREN: begin
            if (c == "*") begin mode = ots_pkg::M_COMMENT; return 0; end
            tok_size = 1;
            close_tok(ots_pkg::C_LBR);
            return 1;
         end
         ots_pkg::M_COMMENT: begin
            if (c == "*") mode = ots_pkg::M_CSTAR;
            return 0;
         end
         ots_pkg::M_CSTAR: begin
            if (c == ")") mode = ots_pkg::M_IDLE;
            else if (c != "*") mode = ots_pkg::M_COMMENT;
            return 0;
         end
         ots_pkg::M_LT, ots_pkg::M_GT, ots_pkg::M_COLON: begin
            one = mode == ots_pkg::M_LT ? ots_pkg::C_LESS :
                  mode == ots_pkg::M_GT ? ots_pkg::C_GREAT : ots_pkg::C_COLON;
            two = mode == ots_pkg::M_LT ? ots_pkg::C_LESSEQ :
                  mode == ots_pkg::M_GT ? ots_pkg::C_GREATEQ : ots_pkg::C_ASSIGN;
            if (c == "=") begin tok_size = 2; close_tok(two); return 0; end
            tok_size = 1;
            close_tok(one);
            return 1;
         end
         default: return 1;
      endcase
   endfunction

   // finish whatever is open at the end of the text
   function void end_text(logic [31:0] p);
      case (mode)
         ots_pkg::M_NAME: close_tok(word_class());
         ots_pkg::M_ZEROS, ots_pkg::M_DEC: close_tok(ots_pkg::C_INTDEC);
         ots_pkg::M_HEX: halt(p, ots_pkg::E_HEX);
         ots_pkg::M_FRAC, ots_pkg::M_EXPDIG: close_tok(ots_pkg::C_REAL);
         ots_pkg::M_EXPSIGN, ots_pkg::M_EXPFIRST: halt(p, ots_pkg::E_EXP);
         ots_pkg::M_STRING: halt(p, ots_pkg::E_STRING);
         ots_pkg::M_PAREN: begin tok_size = 1; close_tok(ots_pkg::C_LBR); end
         ots_pkg::M_COMMENT, ots_pkg::M_CSTAR: halt(p, ots_pkg::E_COMMENT);
         ots_pkg::M_LT: begin tok_size = 1; close_tok(ots_pkg::C_LESS); end
         ots_pkg::M_GT: begin tok_size = 1; close_tok(ots_pkg::C_GREAT); end
         ots_pkg::M_COLON: begin tok_size = 1; close_tok(ots_pkg::C_COLON); end
         default: ;
      endcase
   endfunction

   // note one accepted byte and queue the tokens it causes
   function void note_byte(logic [7:0] c, logic fin);
      logic [31:0] p;
      bit again;
      p = pos_count;
      again = 1;
      step_out.delete();
      if (stopped) return;
      if (mode != ots_pkg::M_IDLE) again = in_token(c, p);
      if (!stopped && again) from_idle(c, p);
      if (!stopped && fin) end_text(p);
      if (!stopped && fin && step_out.size() == 0) push(ots_pkg::C_NONE, p, 0, ots_pkg::E_OK);
      if (stopped || fin) step_out[step_out.size() - 1].last = 1;
      if (!stopped && fin) begin
         mode = ots_pkg::M_IDLE;
         name_len = 0;
         tok_begin = 0;
         tok_size = 0;
         pos_count = 0;
      end else begin
         pos_count = p + 1;
      end
      foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
   endfunction

   function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %0s: got %0h expected %0h (token %0d)", what, got, want, checked);
   endfunction

   // compare one accepted token beat with the oldest expectation
   function void check_token(logic [63:0] d, logic l);
      token_type e;
      if (pending_tokens.size() == 0) begin
         report("unexpected token", d, 0);
         return;
      end
      e = pending_tokens.pop_front();
      if (d[6:0] !== e.cls) report("class", d[6:0], e.cls);
      if (d[38:7] !== e.start) report("start", d[38:7], e.start);
      if (d[54:39] !== e.len) report("length", d[54:39], e.len);
      if (d[57:55] !== e.err) report("error", d[57:55], e.err);
      if (d[63:58] !== 0) report("fill", d[63:58], 0);
      if (l !== e.last) report("last", l, e.last);
      checked++;
   endfunction
endclass

module tb;
   import ots_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   token_scoreboard sb;
   logic [7:0]  text_q[$];
   logic        fin_q[$];
   bit          sending_done;
   int          hold_len;
   int          sent_bytes;

   oberon_token_scanner uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // queue a piece of text, optionally closing it with the end flag
   task automatic add_text(string s, bit close_it);
      for (int i = 0; i < s.len(); i++) begin
         text_q.push_back(s[i]);
         fin_q.push_back(close_it && i == s.len() - 1);
      end
   endtask

   function automatic string pick(string opts[$]);
      return opts[$urandom_range(0, opts.size() - 1)];
   endfunction

   // one random lexeme, mostly well formed
   function automatic string rand_lexeme();
      string s;
      int k;
      string words[$] = '{"ARRAY", "OF", "PROCEDURE", "BEGIN", "END", "RETURN",
         "RECORD", "POINTER", "TO", "IN", "IS", "OR", "DIV", "MOD", "FALSE",
         "TRUE", "NIL", "IF", "THEN", "ELSIF", "ELSE", "CASE", "WHILE", "DO",
         "REPEAT", "UNTIL", "FOR", "BY", "CONST", "TYPE", "VAR", "MODULE",
         "IMPORT", "INTEGER", "begin", "PROCEDUR", "ELSIFX", "x1", "MODULES"};
      string syms[$] = '{"+", "-", "*", "/", "#", "=", "~", "&", ";", ")", "[",
         "]", "{", "}", ":", ":=", "<", "<=", ">", ">=", "(", "(* c *)"};
      s = "";
      k = $urandom_range(0, 9);
      case (k)
         0, 1: s = pick(words);
         2: begin
            k = $urandom_range(1, 20);
            for (int i = 0; i < k; i++)
               s = {s, string'(8'($urandom_range(0, 1) ? $urandom_range(65, 90)
                                                      : $urandom_range(48, 57)))};
            s = {"Q", s};
         end
         3: begin
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) s = {s, "0"};
            k = $urandom_range(0, 4);
            for (int i = 0; i < k; i++) s = {s, string'(8'($urandom_range(48, 57)))};
            case ($urandom_range(0, 5))
               0: s = {s, "9AFH"};
               1: s = {s, "0X"};
               2: s = {s, "1.25"};
               3: s = {s, "3.5E", pick('{"+", "-", ""}), "17"};
               default: if (s == "") s = "7";
            endcase
         end
         4, 5: s = pick(syms);
         6: begin
            s = "\"";
            k = $urandom_range(0, 5);
            for (int i = 0; i < k; i++) s = {s, string'(8'($urandom_range(35, 126)))};
            s = {s, "\""};
         end
         7: s = pick('{" ", "  ", "\n", "\t"});
         8: s = {"(*", pick('{"x", "**", "(", " a*b "}), "*)"};
         default: s = string'(8'($urandom_range(0, 255)));
      endcase
      return {s, pick('{" ", "", ""})};
   endfunction

   // a broken ending that halts the scanner
   function automatic string rand_breaker();
      return pick('{"\"open", "(* open", "9AG", "1.5E", "1.5E+x", "0A;"});
   endfunction

   // feed all queued bytes, with random gaps before some of them
   task automatic send_bytes();
      int gap;
      @(negedge clock);
      while (text_q.size() > 0) begin
         gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1;
         req_tdata <= text_q[0];
         req_tlast <= fin_q[0];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sb.note_byte(text_q[0], fin_q[0]);
         void'(text_q.pop_front());
         void'(fin_q.pop_front());
         sent_bytes++;
         @(negedge clock);
      end
      req_tvalid <= 0;
   endtask

   // wait until all expected tokens are checked; halts come last since the bench applies no reset after one
   task automatic wait_drain();
      int guard;
      guard = 0;
      while (sb.pending_tokens.size() > 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // receiver: random stalls, one long hold-off
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (hold_len > 0) begin
            rsp_tready <= 0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         gap = $urandom_range(0, 4) == 0 ? $urandom_range(0, 18) : 0;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   // output monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_token(rsp_tdata, rsp_tlast);
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int texts;
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      hold_len = 0;
      sent_bytes = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: symbols, keywords, numbers, strings, comments, byte extremes
      add_text("PROCEDURE ELSIF MODULE IMPORT x:=0;", 1);
      add_text("000 00 12 0FFH 7X 1.5E-3 2.E9 (a)", 1);
      add_text("\"\"\"s\"<=>=<>:~{}(*c*)#", 1);
      add_text({" ", string'(8'hFF), string'(8'h01), "!$_"}, 0);
      add_text("ABCDEFGHIJKLMNOPQ DIV/", 1);
      add_text(" ", 1);
      send_bytes();
      wait_drain();

      // pressure: hold the receiver while bytes keep coming
      hold_len = 60;
      add_text("a;b;c;d;e;f;g;h;i;j;k;l;m;n;", 1);
      send_bytes();
      wait_drain();

      // random texts of well formed lexemes with noise
      texts = 0;
      while (sent_bytes < 1400) begin
         string t;
         t = "";
         for (int i = $urandom_range(1, 12); i > 0; i--) t = {t, rand_lexeme()};
         add_text(t, $urandom_range(0, 4) != 0);
         send_bytes();
         texts++;
      end
      add_text(" x", 1);
      send_bytes();
      wait_drain();

      // a halting error, then bytes that must be dropped
      add_text({"ok ", rand_breaker()}, 1);
      add_text("IF x THEN", 1);
      send_bytes();
      wait_drain();
      repeat (40) @(posedge clock);

      $display("covered %0d bytes in %0d random texts, %0d tokens checked", sent_bytes,
               texts, sb.checked);
      $display("including keywords, numbers, strings, comments, symbols and a halt");
      if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
